// ----- design/rsp_pkg.sv -----
// ----------------------------------------------------------------------------
// Reference string parser package
// Shared types, character constants and decode functions for the parser.
// ----------------------------------------------------------------------------
package rsp_pkg;

	// Parse phases, in the order in which the fields of a reference string appear.
	typedef enum logic [3:0] {
		PH_PREFIX = 4'd0,
		PH_SERIAL = 4'd1,
		PH_WLIT   = 4'd2,
		PH_WTITLE = 4'd3,
		PH_WOCC   = 4'd4,
		PH_CLIT   = 4'd5,
		PH_CTITLE = 4'd6,
		PH_COCC   = 4'd7,
		PH_NLIT   = 4'd8,
		PH_NODE   = 4'd9,
		PH_DONE   = 4'd10
	} phase_t;

	// Result kinds.
	localparam logic [1:0] KIND_WINDOW  = 2'd0;
	localparam logic [1:0] KIND_CONTROL = 2'd1;
	localparam logic [1:0] KIND_RECORD  = 2'd2;

	// Status codes.
	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_INVALID = 1'b1;

	// Escape decoding stages.
	localparam logic [1:0] ESC_NONE   = 2'd0;
	localparam logic [1:0] ESC_FIRST  = 2'd1;
	localparam logic [1:0] ESC_SECOND = 2'd2;

	// Characters with a meaning of their own.
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_HASH    = 8'h23;
	localparam logic [7:0] CH_PERCENT = 8'h25;

	localparam int POS_W   = 5;
	localparam int SIZE_W  = 7;
	localparam int COUNT_W = 16;

	// One result word as it travels from the parser to the output stage.
	typedef struct packed {
		logic [1:0]         kind;
		logic [7:0]         title_byte;
		logic [31:0]        serial_high;
		logic [31:0]        serial_low;
		logic [COUNT_W-1:0] window_count;
		logic [COUNT_W-1:0] control_count;
		logic [31:0]        node_code;
		logic [SIZE_W-1:0]  window_title_size;
		logic [SIZE_W-1:0]  control_title_size;
		logic               status;
	} item_t;

	// Hex digit value; bit 4 set means the character is not a hex digit.
	function automatic logic [4:0] hex_of(input logic [7:0] c);
		logic [4:0] v;
		v = 5'h10;
		if (c inside {[8'h30:8'h39]}) begin
			v = {1'b0, c[3:0]};
		end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
			v = 5'(c[2:0]) + 5'd9;
		end
		return v;
	endfunction

	// Unreserved characters that may stand in a title unescaped.
	function automatic logic is_plain(input logic [7:0] c);
		return (c inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39],
			8'h2D, 8'h5F, 8'h2E, 8'h7E});
	endfunction

	// Length of the literal that a literal phase matches.
	function automatic logic [POS_W-1:0] lit_len(input phase_t ph);
		logic [POS_W-1:0] n;
		case (ph)
			PH_PREFIX: n = 5'd4;
			PH_WLIT:   n = 5'd8;
			PH_CLIT:   n = 5'd9;
			PH_NLIT:   n = 5'd6;
			default:   n = 5'd0;
		endcase
		return n;
	endfunction

	// Expected character at a position of a literal.
	function automatic logic [7:0] lit_char(input phase_t ph, input logic [POS_W-1:0] pos);
		logic [7:0] c;
		c = 8'h00;
		case (ph)
			PH_PREFIX: begin
				case (pos)
					5'd0:    c = "a";
					5'd1:    c = "x";
					5'd2:    c = "2";
					5'd3:    c = "/";
					default: c = 8'h00;
				endcase
			end
			PH_WLIT: begin
				case (pos)
					5'd0:    c = "/";
					5'd1:    c = "w";
					5'd2:    c = "i";
					5'd3:    c = "n";
					5'd4:    c = "d";
					5'd5:    c = "o";
					5'd6:    c = "w";
					5'd7:    c = ":";
					default: c = 8'h00;
				endcase
			end
			PH_CLIT: begin
				case (pos)
					5'd0:    c = "/";
					5'd1:    c = "c";
					5'd2:    c = "o";
					5'd3:    c = "n";
					5'd4:    c = "t";
					5'd5:    c = "r";
					5'd6:    c = "o";
					5'd7:    c = "l";
					5'd8:    c = ":";
					default: c = 8'h00;
				endcase
			end
			PH_NLIT: begin
				case (pos)
					5'd0:    c = "/";
					5'd1:    c = "n";
					5'd2:    c = "o";
					5'd3:    c = "d";
					5'd4:    c = "e";
					5'd5:    c = ":";
					default: c = 8'h00;
				endcase
			end
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// ----- design/rsp_text_if.sv -----
// ----------------------------------------------------------------------------
// Character channel
// Valid/ready channel carrying one character of a reference string per word.
// ----------------------------------------------------------------------------
interface rsp_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_char;
	logic       is_final;

	modport source (output valid, output in_char, output is_final, input ready);
	modport sink   (input valid, input in_char, input is_final, output ready);
endinterface

// ----- design/rsp_result_if.sv -----
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying decoded title bytes and final records.
// ----------------------------------------------------------------------------
interface rsp_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  title_byte;
	logic [31:0] serial_high;
	logic [31:0] serial_low;
	logic [15:0] window_count;
	logic [15:0] control_count;
	logic [31:0] node_code;
	logic [6:0]  window_title_size;
	logic [6:0]  control_title_size;
	logic        status;

	modport source (output valid, output kind, output title_byte, output serial_high,
		output serial_low, output window_count, output control_count, output node_code,
		output window_title_size, output control_title_size, output status, input ready);
	modport sink (input valid, input kind, input title_byte, input serial_high,
		input serial_low, input window_count, input control_count, input node_code,
		input window_title_size, input control_title_size, input status, output ready);
endinterface

// ----- design/rsp_front.sv -----
// ----------------------------------------------------------------------------
// Parser front end
// Accepts one character per cycle unless the result queue is full, advances
// the parse state and queues any title byte or final record it produces.
// ----------------------------------------------------------------------------
module rsp_front #(
	parameter int TITLE_LIMIT  = 64,
	parameter int LENGTH_LIMIT = 512
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [7:0]     in_char,
	input  logic           is_final,
	input  logic           queue_full,
	output logic           push,
	output rsp_pkg::item_t push_item
);

	localparam int TALLY_W = $clog2(TITLE_LIMIT + 1);
	localparam int TOTAL_W = $clog2(LENGTH_LIMIT + 1);
	localparam logic [TALLY_W-1:0] TALLY_MAX = TALLY_W'(TITLE_LIMIT);
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = TOTAL_W'(LENGTH_LIMIT);

	rsp_pkg::phase_t            phase_q, phase_d, phase_next;
	logic [rsp_pkg::POS_W-1:0]  pos_q, pos_d, pos_inc;
	logic [TOTAL_W-1:0]         total_q, total_d;
	logic [1:0]                 esc_stage_q, esc_stage_d;
	logic [3:0]                 esc_upper_q, esc_upper_d;
	logic [TALLY_W-1:0]         tally_q, tally_d, first_tally_q, first_tally_d;
	logic [31:0]                serial_hi_q, serial_hi_d, serial_lo_q, serial_lo_d;
	logic [31:0]                node_q, node_d;
	logic [15:0]                digit_q, digit_d;
	logic [2:0]                 dcount_q, dcount_d;
	logic                       lead_zero_q, lead_zero_d;
	logic [15:0]                first_occ_q, first_occ_d, second_occ_q, second_occ_d;
	logic                       error_q, error_d;
	logic                       running_q;

	logic [4:0]  hex;
	logic        hex_ok;
	logic        is_digit;
	logic [19:0] scaled;
	logic        put;
	logic [7:0]  put_value;
	logic        got;
	logic [7:0]  got_byte;
	logic        ok;
	logic        accept;

	assign in_ready = running_q && !queue_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		phase_d      = phase_q;
		pos_d        = pos_q;
		total_d      = total_q;
		esc_stage_d  = esc_stage_q;
		esc_upper_d  = esc_upper_q;
		tally_d      = tally_q;
		first_tally_d = first_tally_q;
		serial_hi_d  = serial_hi_q;
		serial_lo_d  = serial_lo_q;
		node_d       = node_q;
		digit_d      = digit_q;
		dcount_d     = dcount_q;
		lead_zero_d  = lead_zero_q;
		first_occ_d  = first_occ_q;
		second_occ_d = second_occ_q;
		error_d      = error_q;
		put          = 1'b0;
		put_value    = in_char;
		got          = 1'b0;
		got_byte     = 8'h00;

		hex        = rsp_pkg::hex_of(in_char);
		hex_ok     = !hex[4];
		is_digit   = in_char inside {[8'h30:8'h39]};
		scaled     = 20'(digit_q) * 20'd10 + 20'(in_char[3:0]);
		pos_inc    = pos_q + 5'd1;
		phase_next = rsp_pkg::phase_t'(4'(phase_q) + 4'd1);

		if (total_q < TOTAL_MAX) begin
			total_d = total_q + 1'b1;
		end

		if (!error_q) begin
			case (phase_q)
				rsp_pkg::PH_PREFIX, rsp_pkg::PH_WLIT, rsp_pkg::PH_CLIT,
				rsp_pkg::PH_NLIT: begin
					if (pos_q >= rsp_pkg::lit_len(phase_q) ||
						in_char != rsp_pkg::lit_char(phase_q, pos_q)) begin
						error_d = 1'b1;
					end else if (pos_inc == rsp_pkg::lit_len(phase_q)) begin
						phase_d = phase_next;
						pos_d   = '0;
					end else begin
						pos_d = pos_inc;
					end
				end
				rsp_pkg::PH_SERIAL: begin
					if (!hex_ok || pos_q > 5'd15) begin
						error_d = 1'b1;
					end else begin
						if (pos_q < 5'd8) begin
							serial_hi_d = {serial_hi_q[27:0], hex[3:0]};
						end else begin
							serial_lo_d = {serial_lo_q[27:0], hex[3:0]};
						end
						if (pos_inc == 5'd16) begin
							phase_d = rsp_pkg::PH_WLIT;
							pos_d   = '0;
						end else begin
							pos_d = pos_inc;
						end
					end
				end
				rsp_pkg::PH_WTITLE, rsp_pkg::PH_CTITLE: begin
					if (esc_stage_q == rsp_pkg::ESC_FIRST) begin
						if (!hex_ok) begin
							error_d = 1'b1;
						end else begin
							esc_upper_d = hex[3:0];
							esc_stage_d = rsp_pkg::ESC_SECOND;
						end
					end else if (esc_stage_q == rsp_pkg::ESC_SECOND) begin
						if (!hex_ok) begin
							error_d = 1'b1;
						end else begin
							esc_stage_d = rsp_pkg::ESC_NONE;
							put         = 1'b1;
							put_value   = {esc_upper_q, hex[3:0]};
						end
					end else if (in_char == rsp_pkg::CH_HASH) begin
						if (phase_q == rsp_pkg::PH_WTITLE) begin
							first_tally_d = tally_q;
							tally_d       = '0;
						end
						phase_d     = phase_next;
						digit_d     = '0;
						dcount_d    = '0;
						lead_zero_d = 1'b0;
					end else if (in_char == rsp_pkg::CH_PERCENT) begin
						esc_stage_d = rsp_pkg::ESC_FIRST;
					end else if (rsp_pkg::is_plain(in_char)) begin
						put = 1'b1;
					end else begin
						error_d = 1'b1;
					end
				end
				rsp_pkg::PH_WOCC, rsp_pkg::PH_COCC: begin
					if (in_char == rsp_pkg::CH_SLASH) begin
						if (dcount_q == 3'd0) begin
							error_d = 1'b1;
						end else begin
							if (phase_q == rsp_pkg::PH_WOCC) begin
								first_occ_d = digit_q;
							end else begin
								second_occ_d = digit_q;
							end
							phase_d = phase_next;
							// the slash is already the first character of the next literal
							pos_d   = 5'd1;
						end
					end else if (!is_digit || lead_zero_q) begin
						error_d = 1'b1;
					end else if (scaled > 20'd65535) begin
						error_d = 1'b1;
					end else begin
						if (dcount_q == 3'd0 && in_char[3:0] == 4'd0) begin
							lead_zero_d = 1'b1;
						end
						digit_d = scaled[15:0];
						if (dcount_q < 3'd7) begin
							dcount_d = dcount_q + 3'd1;
						end
					end
				end
				rsp_pkg::PH_NODE: begin
					if (!hex_ok || pos_q > 5'd7) begin
						error_d = 1'b1;
					end else begin
						node_d = {node_q[27:0], hex[3:0]};
						if (pos_inc == 5'd8) begin
							phase_d = rsp_pkg::PH_DONE;
							pos_d   = '0;
						end else begin
							pos_d = pos_inc;
						end
					end
				end
				default: begin
					error_d = 1'b1;
				end
			endcase

			if (put) begin
				if (tally_q >= TALLY_MAX) begin
					error_d = 1'b1;
				end else begin
					tally_d  = tally_q + 1'b1;
					got      = 1'b1;
					got_byte = put_value;
				end
			end
		end
	end

	assign ok = !error_d && phase_d == rsp_pkg::PH_DONE && total_d < TOTAL_MAX;

	always_comb begin
		push_item = '0;
		if (is_final) begin
			push_item.kind = rsp_pkg::KIND_RECORD;
			if (ok) begin
				push_item.serial_high        = serial_hi_d;
				push_item.serial_low         = serial_lo_d;
				push_item.window_count       = first_occ_d;
				push_item.control_count      = second_occ_d;
				push_item.node_code          = node_d;
				push_item.window_title_size  = rsp_pkg::SIZE_W'(first_tally_d);
				push_item.control_title_size = rsp_pkg::SIZE_W'(tally_d);
				push_item.status             = rsp_pkg::STATUS_OK;
			end else begin
				push_item.status = rsp_pkg::STATUS_INVALID;
			end
		end else begin
			push_item.kind = (phase_q == rsp_pkg::PH_CTITLE) ? rsp_pkg::KIND_CONTROL
				: rsp_pkg::KIND_WINDOW;
			push_item.title_byte = got_byte;
		end
	end

	assign push = accept && (is_final || got);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
		end else begin
			running_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= rsp_pkg::PH_PREFIX;
			pos_q         <= '0;
			total_q       <= '0;
			esc_stage_q   <= rsp_pkg::ESC_NONE;
			esc_upper_q   <= '0;
			tally_q       <= '0;
			first_tally_q <= '0;
			serial_hi_q   <= '0;
			serial_lo_q   <= '0;
			node_q        <= '0;
			digit_q       <= '0;
			dcount_q      <= '0;
			lead_zero_q   <= 1'b0;
			first_occ_q   <= '0;
			second_occ_q  <= '0;
			error_q       <= 1'b0;
		end else if (accept && is_final) begin
			phase_q       <= rsp_pkg::PH_PREFIX;
			pos_q         <= '0;
			total_q       <= '0;
			esc_stage_q   <= rsp_pkg::ESC_NONE;
			esc_upper_q   <= '0;
			tally_q       <= '0;
			first_tally_q <= '0;
			serial_hi_q   <= '0;
			serial_lo_q   <= '0;
			node_q        <= '0;
			digit_q       <= '0;
			dcount_q      <= '0;
			lead_zero_q   <= 1'b0;
			first_occ_q   <= '0;
			second_occ_q  <= '0;
			error_q       <= 1'b0;
		end else if (accept) begin
			phase_q       <= phase_d;
			pos_q         <= pos_d;
			total_q       <= total_d;
			esc_stage_q   <= esc_stage_d;
			esc_upper_q   <= esc_upper_d;
			tally_q       <= tally_d;
			first_tally_q <= first_tally_d;
			serial_hi_q   <= serial_hi_d;
			serial_lo_q   <= serial_lo_d;
			node_q        <= node_d;
			digit_q       <= digit_d;
			dcount_q      <= dcount_d;
			lead_zero_q   <= lead_zero_d;
			first_occ_q   <= first_occ_d;
			second_occ_q  <= second_occ_d;
			error_q       <= error_d;
		end
	end

endmodule

// ----- design/rsp_queue.sv -----
// ----------------------------------------------------------------------------
// Result queue
// Short first-in first-out queue between the parser and the output stage.
// ----------------------------------------------------------------------------
module rsp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rsp_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output rsp_pkg::item_t head_item
);

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);
	localparam logic [PTR_W:0] COUNT_FULL = (PTR_W + 1)'(DEPTH);

	rsp_pkg::item_t   entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full      = (count_q == COUNT_FULL);
	assign not_empty = (count_q != '0);
	assign head_item = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- design/rsp_back.sv -----
// ----------------------------------------------------------------------------
// Output stage
// Holds the result word shown on the output channel and refills it from the
// queue whenever it is empty or being taken.
// ----------------------------------------------------------------------------
module rsp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  rsp_pkg::item_t head_item,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output rsp_pkg::item_t out_item
);

	logic           valid_q;
	rsp_pkg::item_t item_q;

	assign pop       = head_valid && (!valid_q || out_ready);
	assign out_valid = valid_q;
	assign out_item  = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= head_item;
		end
	end

endmodule

// ----- design/reference_string_parser.sv -----
// ----------------------------------------------------------------------------
// Reference string parser
// Streams a textual reference string in, emits decoded title bytes and one
// summary record per string.
// ----------------------------------------------------------------------------
// Usage: the text channel takes one character per word, the last character of
// a string marked by is_final. The result channel gives every decoded title
// byte (kind window or control) as soon as it completes, and on the last
// character one record carrying the serial, occurrences, node code, title
// sizes and a status. Bytes already given belong to the string only when the
// record's status is ok; an invalid record carries zero in every number.
// Throughput: one character per cycle while text.ready is high, since the
// parse state is updated once per character. A result word is registered in
// the queue and then in the output stage before it appears on the result
// channel. The parser pushes into a four-word queue and a registered output
// stage drains it, so a stalled receiver does not hold up input until the
// queue fills; text.ready then falls. Reset clears the parse state and the
// queue; text.ready stays low until the clock sets it after reset is released.
// ----------------------------------------------------------------------------
module reference_string_parser #(
	parameter int TITLE_LIMIT  = 64,
	parameter int LENGTH_LIMIT = 512
) (
	input  logic                clk,
	input  logic                arst_n,
	rsp_text_if.sink            text,
	rsp_result_if.source        result
);

	logic           push;
	rsp_pkg::item_t push_item;
	logic           queue_full;
	logic           pop;
	logic           head_valid;
	rsp_pkg::item_t head_item;
	rsp_pkg::item_t out_item;

	// Front end: character classification and the parse state machine.
	rsp_front #(
		.TITLE_LIMIT  (TITLE_LIMIT),
		.LENGTH_LIMIT (LENGTH_LIMIT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (text.valid),
		.in_ready   (text.ready),
		.in_char    (text.in_char),
		.is_final   (text.is_final),
		.queue_full (queue_full),
		.push       (push),
		.push_item  (push_item)
	);

	// Queue that decouples the parser from the receiver.
	rsp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (queue_full),
		.pop       (pop),
		.not_empty (head_valid),
		.head_item (head_item)
	);

	// Back end: the registered output word.
	rsp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop),
		.out_valid  (result.valid),
		.out_ready  (result.ready),
		.out_item   (out_item)
	);

	assign result.kind               = out_item.kind;
	assign result.title_byte         = out_item.title_byte;
	assign result.serial_high        = out_item.serial_high;
	assign result.serial_low         = out_item.serial_low;
	assign result.window_count       = out_item.window_count;
	assign result.control_count      = out_item.control_count;
	assign result.node_code          = out_item.node_code;
	assign result.window_title_size  = out_item.window_title_size;
	assign result.control_title_size = out_item.control_title_size;
	assign result.status             = out_item.status;

endmodule

// ----- design/rsp_checker.sv -----
// ----------------------------------------------------------------------------
// Reference string parser checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module rsp_checker #(
	parameter int TITLE_LIMIT = 64
) (
	input logic        clk,
	input logic        arst_n,
	input logic        text_valid,
	input logic        text_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic [1:0]  kind,
	input logic [7:0]  title_byte,
	input logic [31:0] serial_high,
	input logic [31:0] serial_low,
	input logic [15:0] window_count,
	input logic [15:0] control_count,
	input logic [31:0] node_code,
	input logic [6:0]  window_title_size,
	input logic [6:0]  control_title_size,
	input logic        status
);

	// A stalled result word holds.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(kind) && $stable(title_byte)
		&& $stable(status) && $stable(serial_high) && $stable(node_code))
		else $error("result word changed while stalled");

	// A word on an idle output was caused by a character accepted earlier.
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(text_valid && text_ready, 2))
		else $error("result word without a character two cycles before");

	// Title bytes carry nothing but the byte.
	a_title_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind != rsp_pkg::KIND_RECORD |->
		(kind == rsp_pkg::KIND_WINDOW || kind == rsp_pkg::KIND_CONTROL) &&
		status == rsp_pkg::STATUS_OK && serial_high == 32'd0 && serial_low == 32'd0 &&
		node_code == 32'd0 && window_title_size == 7'd0 && control_title_size == 7'd0)
		else $error("title byte word with stray fields");

	// Invalid records are all zero; valid records keep titles within the limit.
	a_record: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind == rsp_pkg::KIND_RECORD |->
		(status == rsp_pkg::STATUS_INVALID) ?
		(serial_high == 32'd0 && serial_low == 32'd0 && window_count == 16'd0 &&
		control_count == 16'd0 && node_code == 32'd0 && title_byte == 8'd0 &&
		window_title_size == 7'd0 && control_title_size == 7'd0) :
		(32'(window_title_size) <= TITLE_LIMIT && 32'(control_title_size) <= TITLE_LIMIT
		&& title_byte == 8'd0))
		else $error("record fields inconsistent with status");

endmodule

bind reference_string_parser rsp_checker #(
	.TITLE_LIMIT (TITLE_LIMIT)
) u_rsp_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.text_valid         (text.valid),
	.text_ready         (text.ready),
	.res_valid          (result.valid),
	.res_ready          (result.ready),
	.kind               (result.kind),
	.title_byte         (result.title_byte),
	.serial_high        (result.serial_high),
	.serial_low         (result.serial_low),
	.window_count       (result.window_count),
	.control_count      (result.control_count),
	.node_code          (result.node_code),
	.window_title_size  (result.window_title_size),
	.control_title_size (result.control_title_size),
	.status             (result.status)
);
